@@ design/dg3_pkg.sv @@
// ----------------------------------------------------------------------------
// dg3_pkg
// Shared types and constants of the directional 3x3 gradient block.
// ----------------------------------------------------------------------------
`default_nettype none

package dg3_pkg;

	// configuration port
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 13;
	localparam int WIDTH_REG_BITS  = 12;
	localparam int HEIGHT_REG_BITS = 13;
	localparam int SHIFT_BITS      = 4;

	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

	localparam cfg_index_t CFG_IMAGE_WIDTH     = 2'd0;
	localparam cfg_index_t CFG_IMAGE_HEIGHT    = 2'd1;
	localparam cfg_index_t CFG_THRESHOLD_SHIFT = 2'd2;

	// frame geometry limits
	localparam int MIN_SIZE   = 3;
	localparam int MAX_HEIGHT = 4096;

	// width of column compares, wide enough for any width setting
	localparam int COL_CMP_BITS = 14;
	localparam int ROW_BITS     = 12;

	// result field widths
	localparam int MAG_BITS = 8;
	localparam int DIR_BITS = 2;
	localparam int CX_BITS  = 11;
	localparam int CY_BITS  = 12;

	typedef logic [DIR_BITS-1:0] dir_t;

	localparam dir_t DIR_VERTICAL   = 2'd0;
	localparam dir_t DIR_ANTIDIAG   = 2'd1;
	localparam dir_t DIR_HORIZONTAL = 2'd2;
	localparam dir_t DIR_DIAGONAL   = 2'd3;

	// effective frame settings seen by the datapath
	typedef struct packed {
		logic [COL_CMP_BITS-1:0]    width;
		logic [HEIGHT_REG_BITS-1:0] height;
		logic [SHIFT_BITS-1:0]      shift;
	} geom_t;

	// position of a window center as it moves down the pipeline
	typedef struct packed {
		logic [CX_BITS-1:0] cx;
		logic [CY_BITS-1:0] cy;
		logic               interior;
	} pos_t;

	typedef struct packed {
		logic [MAG_BITS-1:0] magnitude;
		dir_t                direction;
		logic [CX_BITS-1:0]  center_x;
		logic [CY_BITS-1:0]  center_y;
		logic                result_valid;
	} result_t;

endpackage

`default_nettype wire

@@ design/dg3_cfg_if.sv @@
// ----------------------------------------------------------------------------
// dg3_cfg_if
// Register write channel: valid/ready with register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface dg3_cfg_if import dg3_pkg::*; ();

	logic                     valid;
	logic                     ready;
	cfg_index_t               index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);

endinterface

`default_nettype wire

@@ design/dg3_pix_if.sv @@
// ----------------------------------------------------------------------------
// dg3_pix_if
// Pixel stream channel: valid/ready with one raster-order pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface dg3_pix_if #(
	parameter int PIXEL_BITS = 8
) ();

	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);

endinterface

`default_nettype wire

@@ design/dg3_res_if.sv @@
// ----------------------------------------------------------------------------
// dg3_res_if
// Result stream channel: valid/ready with gradient magnitude, direction
// and center position.
// ----------------------------------------------------------------------------
`default_nettype none

interface dg3_res_if import dg3_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [MAG_BITS-1:0] magnitude;
	logic [DIR_BITS-1:0] direction;
	logic [CX_BITS-1:0]  center_x;
	logic [CY_BITS-1:0]  center_y;
	logic                result_valid;

	modport source (
		output valid, output magnitude, output direction,
		output center_x, output center_y, output result_valid,
		input ready
	);
	modport sink (
		input valid, input magnitude, input direction,
		input center_x, input center_y, input result_valid,
		output ready
	);

endinterface

`default_nettype wire

@@ design/dg3_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dg3_cfg_regs
// Configuration registers with saturation of width and height to the
// supported range.
// ----------------------------------------------------------------------------
`default_nettype none

module dg3_cfg_regs import dg3_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dg3_cfg_if.sink   cfg,
	output geom_t     geom
);

	logic [WIDTH_REG_BITS-1:0]  width_q;
	logic [HEIGHT_REG_BITS-1:0] height_q;
	logic [SHIFT_BITS-1:0]      shift_q;
	logic [COL_CMP_BITS-1:0]    width_ext;

	// writes are taken at any time
	assign cfg.ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_REG_BITS'(640);
			height_q <= HEIGHT_REG_BITS'(480);
			shift_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_IMAGE_WIDTH:     width_q  <= cfg.data[WIDTH_REG_BITS-1:0];
				CFG_IMAGE_HEIGHT:    height_q <= cfg.data[HEIGHT_REG_BITS-1:0];
				CFG_THRESHOLD_SHIFT: shift_q  <= cfg.data[SHIFT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// saturate to the supported frame size
	assign width_ext = COL_CMP_BITS'(width_q);

	always_comb begin
		if (width_ext < COL_CMP_BITS'(MIN_SIZE))
			geom.width = COL_CMP_BITS'(MIN_SIZE);
		else if (width_ext > COL_CMP_BITS'(MAX_WIDTH))
			geom.width = COL_CMP_BITS'(MAX_WIDTH);
		else
			geom.width = width_ext;

		if (height_q < HEIGHT_REG_BITS'(MIN_SIZE))
			geom.height = HEIGHT_REG_BITS'(MIN_SIZE);
		else if (height_q > HEIGHT_REG_BITS'(MAX_HEIGHT))
			geom.height = HEIGHT_REG_BITS'(MAX_HEIGHT);
		else
			geom.height = height_q;

		geom.shift = shift_q;
	end

endmodule

`default_nettype wire

@@ design/dg3_line_store.sv @@
// ----------------------------------------------------------------------------
// dg3_line_store
// Two row memories (row y-2 and row y-1) sharing one address space, one
// read port and one write port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dg3_line_store #(
	parameter int DEPTH      = 2048,
	parameter int ADDR_BITS  = 11,
	parameter int PIXEL_BITS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  rd_en,
	input  wire logic [ADDR_BITS-1:0]  rd_addr,
	input  wire logic                  wr_en,
	input  wire logic [ADDR_BITS-1:0]  wr_addr,
	input  wire logic [PIXEL_BITS-1:0] wr_upper,
	input  wire logic [PIXEL_BITS-1:0] wr_middle,
	output logic      [PIXEL_BITS-1:0] rd_upper,
	output logic      [PIXEL_BITS-1:0] rd_middle
);

	logic [PIXEL_BITS-1:0] upper_mem  [DEPTH];
	logic [PIXEL_BITS-1:0] middle_mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr]  <= wr_upper;
			middle_mem[wr_addr] <= wr_middle;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_upper  <= upper_mem[rd_addr];
			rd_middle <= middle_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ design/dg3_grad_eval.sv @@
// ----------------------------------------------------------------------------
// dg3_grad_eval
// Picks the strongest of four center differences, forms the thresholded
// mean and holds the finished result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dg3_grad_eval import dg3_pkg::*; #(
	parameter int PIXEL_BITS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       load,
	input  wire logic [3:0][PIXEL_BITS-1:0] diff,
	input  wire pos_t                       pos,
	input  wire logic [SHIFT_BITS-1:0]      shift,
	output result_t                         res_q
);

	// diff order: horizontal, diagonal, vertical, antidiagonal
	logic [PIXEL_BITS-1:0] best;
	dir_t                  code;
	logic [PIXEL_BITS+1:0] sum;
	logic [PIXEL_BITS-1:0] mean;
	logic [PIXEL_BITS-1:0] mag;
	result_t               res_d;

	// strongest direction, earlier one wins a tie
	always_comb begin
		best = diff[0];
		code = DIR_HORIZONTAL;
		if (best < diff[1]) begin
			best = diff[1];
			code = DIR_DIAGONAL;
		end
		if (best < diff[2]) begin
			best = diff[2];
			code = DIR_VERTICAL;
		end
		if (best < diff[3]) begin
			best = diff[3];
			code = DIR_ANTIDIAG;
		end
	end

	// mean of the four differences and threshold
	always_comb begin
		sum  = (PIXEL_BITS+2)'(diff[0]) + (PIXEL_BITS+2)'(diff[1])
		     + (PIXEL_BITS+2)'(diff[2]) + (PIXEL_BITS+2)'(diff[3]);
		mean = sum[PIXEL_BITS+1:2];
		mag  = ((mean >> shift) == '0) ? '0 : mean;
	end

	// border centers give an all-zero result
	always_comb begin
		res_d = '0;
		if (pos.interior) begin
			res_d.magnitude    = mag[MAG_BITS-1:0];
			res_d.direction    = code;
			res_d.center_x     = pos.cx;
			res_d.center_y     = pos.cy;
			res_d.result_valid = 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_d;
	end

endmodule

`default_nettype wire

@@ design/directional_gradient_3x3.sv @@
// ----------------------------------------------------------------------------
// directional_gradient_3x3
// Streaming four-direction gradient over a 3x3 window of a raster frame.
// ----------------------------------------------------------------------------
// Pixels enter on the pixels channel in raster order; each transfer gives
// exactly one transfer on the results channel, in the same order. The
// result belongs to the window centered one column and one row back; border
// centers carry result_valid low and all other fields zero.
// Registers are written on the cfg channel (0 width, 1 height, 2 threshold
// shift); cfg.ready is always high. The user is to write them only while
// no pixel is in flight; the block itself does not enforce this. A result
// passes stage 1, stage 2 and the output register before it is presented.
// Throughput: one pixel per cycle while results are taken, set by the
// single read and single write of the line-store memories per pixel
// (read on transfer, write back when stage 1 moves on, same column address
// for both rows). A stalled receiver fills the output register, then the
// two internal stages, after which pixels.ready drops; no result is lost.
// Reset clears the pipeline, the window and the column/row counters and
// loads width 640, height 480, shift 0. The line stores are not cleared;
// only interior results read them, and after a geometry change mid-frame
// those can read entries written in an earlier frame.
// ----------------------------------------------------------------------------
`default_nettype none

module directional_gradient_3x3 import dg3_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int PIXEL_BITS = 8
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	dg3_cfg_if.sink     cfg,
	dg3_pix_if.sink     pixels,
	dg3_res_if.source   results
);

	localparam int AW = $clog2(MAX_WIDTH);

	geom_t geom;

	// handshake and stage valids
	logic res_v_q;
	logic s1_v_q;
	logic s2_v_q;
	logic out_free;
	logic s2_ready;
	logic s1_ready;
	logic acc;
	logic s1_go;
	logic s2_go;

	// position counters
	logic [AW-1:0]           col_q;
	logic [ROW_BITS-1:0]     row_q;
	logic [COL_CMP_BITS-1:0] col_ext;
	logic [COL_CMP_BITS-1:0] col_inc;
	logic [HEIGHT_REG_BITS-1:0] row_ext;
	logic [HEIGHT_REG_BITS-1:0] row_inc;
	pos_t                    pos_d;

	// stage 1
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [AW-1:0]         col_s1;
	pos_t                  pos_s1;
	logic [PIXEL_BITS-1:0] rd_upper;
	logic [PIXEL_BITS-1:0] rd_middle;
	logic [PIXEL_BITS-1:0] win_q [6];
	logic [3:0][PIXEL_BITS-1:0] diff_d;

	// stage 2
	logic [3:0][PIXEL_BITS-1:0] diff_s2;
	pos_t                       pos_s2;

	result_t res;

	// register file
	dg3_cfg_regs #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.geom   (geom)
	);

	// pipeline flow control
	assign out_free     = !res_v_q || results.ready;
	assign s2_ready     = !s2_v_q || out_free;
	assign s1_ready     = !s1_v_q || s2_ready;
	assign pixels.ready = s1_ready;
	assign acc          = pixels.valid && s1_ready;
	assign s1_go        = s1_v_q && s2_ready;
	assign s2_go        = s2_v_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (s1_ready)
				s1_v_q <= acc;
			if (s2_ready)
				s2_v_q <= s1_v_q;
			if (out_free)
				res_v_q <= s2_v_q;
		end
	end

	// center position and border check of the incoming pixel
	always_comb begin
		col_ext = COL_CMP_BITS'(col_q);
		col_inc = col_ext + COL_CMP_BITS'(1);
		row_ext = HEIGHT_REG_BITS'(row_q);
		row_inc = row_ext + HEIGHT_REG_BITS'(1);
		pos_d.interior = (col_ext >= COL_CMP_BITS'(2)) && (col_ext < geom.width)
		              && (row_ext >= HEIGHT_REG_BITS'(2)) && (row_ext < geom.height);
		pos_d.cx = CX_BITS'(col_ext - COL_CMP_BITS'(1));
		pos_d.cy = CY_BITS'(row_ext - HEIGHT_REG_BITS'(1));
	end

	// raster counters, wrap at the effective frame size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_inc >= geom.width) begin
				col_q <= '0;
				row_q <= (row_inc >= geom.height) ? '0 : row_inc[ROW_BITS-1:0];
			end else begin
				col_q <= col_inc[AW-1:0];
			end
		end
	end

	// stage 1 registers, loaded on pixel transfer
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1 <= pixels.pixel;
			col_s1 <= col_q;
			pos_s1 <= pos_d;
		end
	end

	// line stores: read on transfer, write back when stage 1 moves on
	dg3_line_store #(
		.DEPTH      (MAX_WIDTH),
		.ADDR_BITS  (AW),
		.PIXEL_BITS (PIXEL_BITS)
	) u_lines (
		.clk       (clk),
		.rd_en     (acc),
		.rd_addr   (col_q),
		.wr_en     (s1_go),
		.wr_addr   (col_s1),
		.wr_upper  (rd_middle),
		.wr_middle (pix_s1),
		.rd_upper  (rd_upper),
		.rd_middle (rd_middle)
	);

	// absolute differences across the center
	// window: 0..2 left column, 3..5 center column, top to bottom
	always_comb begin
		diff_d[0] = (win_q[1] >= rd_middle) ? win_q[1] - rd_middle : rd_middle - win_q[1];
		diff_d[1] = (win_q[0] >= pix_s1) ? win_q[0] - pix_s1 : pix_s1 - win_q[0];
		diff_d[2] = (win_q[3] >= win_q[5]) ? win_q[3] - win_q[5] : win_q[5] - win_q[3];
		diff_d[3] = (rd_upper >= win_q[2]) ? rd_upper - win_q[2] : win_q[2] - rd_upper;
	end

	// window shift by one column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (s1_go) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= rd_upper;
			win_q[4] <= rd_middle;
			win_q[5] <= pix_s1;
		end
	end

	// stage 2 registers
	always_ff @(posedge clk) begin
		if (s1_go) begin
			diff_s2 <= diff_d;
			pos_s2  <= pos_s1;
		end
	end

	// direction, magnitude and output register
	dg3_grad_eval #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_eval (
		.clk   (clk),
		.load  (s2_go),
		.diff  (diff_s2),
		.pos   (pos_s2),
		.shift (geom.shift),
		.res_q (res)
	);

	assign results.valid        = res_v_q;
	assign results.magnitude    = res.magnitude;
	assign results.direction    = res.direction;
	assign results.center_x     = res.center_x;
	assign results.center_y     = res.center_y;
	assign results.result_valid = res.result_valid;

	// a transfer always lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> s1_v_q)
		else $error("pixel transfer did not reach stage 1");

	// a stalled stage 1 keeps its pixel and column
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && !s2_ready) |=> (s1_v_q && $stable(col_s1) && $stable(pix_s1)))
		else $error("stage 1 changed while stalled");

	// the line-store read never hits the entry being written back
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s1_go) |-> (col_q != col_s1))
		else $error("line store read and write at the same column");

	// border results carry zero fields
	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && !res.result_valid) |->
			(res.magnitude == '0 && res.direction == '0
			 && res.center_x == '0 && res.center_y == '0))
		else $error("border result with nonzero fields");

endmodule

`default_nettype wire

@@ tb/tb_directional_gradient_3x3.sv @@
// ----------------------------------------------------------------------------
// tb_directional_gradient_3x3
// Self-checking bench for the streaming 3x3 directional gradient block.
// ----------------------------------------------------------------------------
// Pixels go in on the pixel channel and results are checked field by field
// against an in-bench gradient predictor, in transfer order.
// A short table of hand-checked frames comes first: border results,
// four-way ties at full scale, and a direction that survives a threshold
// that zeroes the magnitude.
// Three geometry cases follow: one frame at the widest random row, part of
// a row under a saturated width that a shrink then cuts short, and a tall
// saturated height that a later shrink cuts short mid-frame.
// The rest is random frames, whole and partial, under random geometry
// and threshold settings, including out-of-range register values.
// Both channels idle at random. The result side also holds off for long
// stretches so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------

module tb_directional_gradient_3x3 import dg3_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W          = 2048;
	localparam int PIX_BITS       = 8;
	localparam int RANDOM_ITEMS   = 1580;
	localparam int WIDE_ROW       = 32;
	localparam int SAT_ROW_PIXELS = 32;
	localparam int TALL_PIXELS    = 3 * 40 + 2;
	localparam int CYCLE_LIMIT    = 300000;
	localparam int HOLD_EVERY     = 1000;
	localparam int HOLD_CYCLES    = 64;
	localparam int CALM_START     = 1000;
	localparam int CALM_END       = 1400;
	localparam int IDLE_PCT       = 12;
	localparam int SHOWN_ERRORS   = 40;

	// index with no register behind it; writes to it change nothing
	localparam cfg_index_t CFG_SPARE_INDEX = 2'd3;

	localparam result_t BORDER_RESULT = '0;
	localparam result_t PEAK_TIE      = result_t'{8'd255, DIR_HORIZONTAL, 11'd1, 12'd1, 1'b1};
	localparam result_t ANTIDIAG_CUT  = result_t'{8'd0, DIR_ANTIDIAG, 11'd1, 12'd1, 1'b1};

	typedef struct {
		bit                       is_write;
		cfg_index_t               index;
		logic [CFG_DATA_BITS-1:0] data;
		logic [PIX_BITS-1:0]      pixel;
		result_t                  want;
	} directed_row_t;

	logic clk;
	logic arst_n;
	int   cycles = 0;

	dg3_cfg_if                          cfg_ch ();
	dg3_pix_if #(.PIXEL_BITS(PIX_BITS)) pix_ch ();
	dg3_res_if                          res_ch ();

	directional_gradient_3x3 #(
		.MAX_WIDTH (MAX_W),
		.PIXEL_BITS(PIX_BITS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.pixels (pix_ch),
		.results(res_ch)
	);

	// predictor state: register copies, line stores, window, raster position
	logic [WIDTH_REG_BITS-1:0]  reg_width;
	logic [HEIGHT_REG_BITS-1:0] reg_height;
	logic [SHIFT_BITS-1:0]      reg_shift;
	bit [PIX_BITS-1:0]          row_two_back [MAX_W];
	bit [PIX_BITS-1:0]          row_one_back [MAX_W];
	bit [PIX_BITS-1:0]          win_px [6];
	int                         next_col;
	int                         next_row;
	bit [PIX_BITS-1:0]          level;

	result_t       expected_results [$];
	directed_row_t directed_rows [$];
	bit            writing;
	int            pixels_sent;
	int            reg_writes;
	int            settings_used;
	int            results_checked;
	int            interior_seen;
	int            mismatches;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// cycle count and run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_results.size());
			$display("FAIL directional_gradient_3x3");
			$finish;
		end
	end

	function automatic bit calm_stretch();
		return cycles >= CALM_START && cycles < CALM_END;
	endfunction

	function automatic int pixel_gap(input bit [PIX_BITS-1:0] a, input bit [PIX_BITS-1:0] b);
		return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	// one raster step: result for the window centered one column and one row back
	function automatic result_t predict_gradient(input bit [PIX_BITS-1:0] value);
		int              eff_w, eff_h, c, r;
		int              d_h, d_d, d_v, d_a, best, mean;
		bit [PIX_BITS-1:0] up, mid;
		result_t         res;
		eff_w = (reg_width < MIN_SIZE) ? MIN_SIZE : (reg_width > MAX_W) ? MAX_W : int'(reg_width);
		eff_h = (reg_height < MIN_SIZE) ? MIN_SIZE :
			(reg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(reg_height);
		c = next_col;
		r = next_row;
		up = row_two_back[c];
		mid = row_one_back[c];
		row_two_back[c] = mid;
		row_one_back[c] = value;
		res = '0;
		if (c >= 2 && c < eff_w && r >= 2 && r < eff_h) begin
			d_h = pixel_gap(win_px[1], mid);
			d_d = pixel_gap(win_px[0], value);
			d_v = pixel_gap(win_px[3], win_px[5]);
			d_a = pixel_gap(up, win_px[2]);
			// strict compares: on a tie the earlier direction stays
			best = d_h;
			res.direction = DIR_HORIZONTAL;
			if (best < d_d) begin
				best = d_d;
				res.direction = DIR_DIAGONAL;
			end
			if (best < d_v) begin
				best = d_v;
				res.direction = DIR_VERTICAL;
			end
			if (best < d_a) begin
				best = d_a;
				res.direction = DIR_ANTIDIAG;
			end
			mean = (d_h + d_d + d_v + d_a) >> 2;
			if ((mean >> reg_shift) == 0)
				mean = 0;
			res.magnitude = 8'(mean);
			res.center_x = 11'(c - 1);
			res.center_y = 12'(r - 1);
			res.result_valid = 1'b1;
		end
		// slide the window one column
		win_px[0] = win_px[3];
		win_px[1] = win_px[4];
		win_px[2] = win_px[5];
		win_px[3] = up;
		win_px[4] = mid;
		win_px[5] = value;
		// raster position, wrapping at once when left beyond a smaller frame
		if (c + 1 >= eff_w) begin
			next_col = 0;
			next_row = (r + 1 >= eff_h) ? 0 : r + 1;
		end else begin
			next_col = c + 1;
		end
		return res;
	endfunction

	// pixel mix: noise, flat areas with small ripple, hard black/white edges
	function automatic bit [PIX_BITS-1:0] next_pixel();
		int pick, v;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 5)
			level = PIX_BITS'($urandom_range(0, 255));
		if (pick < 40)
			return PIX_BITS'($urandom_range(0, 255));
		if (pick < 80) begin
			v = int'(level) + int'($urandom_range(0, 8)) - 4;
			v = (v < 0) ? 0 : (v > 255) ? 255 : v;
			return PIX_BITS'(v);
		end
		return $urandom_range(0, 1) ? 8'hFF : 8'h00;
	endfunction

	function automatic directed_row_t reg_row(input cfg_index_t idx,
		input logic [CFG_DATA_BITS-1:0] value);
		directed_row_t row;
		row = '{is_write: 1'b1, index: idx, data: value, pixel: '0, want: '0};
		return row;
	endfunction

	function automatic directed_row_t pix_row(input logic [PIX_BITS-1:0] value,
		input result_t want);
		directed_row_t row;
		row = '{is_write: 1'b0, index: '0, data: '0, pixel: value, want: want};
		return row;
	endfunction

	function automatic void check_field(input string name, input logic [11:0] want,
		input logic [11:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= SHOWN_ERRORS)
				$display("t=%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// wait until every pixel sent has its result back, then sync to a rising edge
	task automatic drain();
		pix_ch.valid <= 1'b0;
		if (writing) begin
			cfg_ch.valid <= 1'b0;
			writing = 1'b0;
		end
		while (expected_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// register write transfer; valid stays high for a following write
	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		writing = 1'b1;
		reg_writes++;
		case (idx)
			CFG_IMAGE_WIDTH:     reg_width = value[WIDTH_REG_BITS-1:0];
			CFG_IMAGE_HEIGHT:    reg_height = value[HEIGHT_REG_BITS-1:0];
			CFG_THRESHOLD_SHIFT: reg_shift = value[SHIFT_BITS-1:0];
			default: ;
		endcase
	endtask

	// pixel transfer with optional idle cycles ahead of it
	task automatic send_pixel(input logic [PIX_BITS-1:0] value, input bit typed,
		input result_t typed_want);
		result_t predicted;
		if (writing) begin
			cfg_ch.valid <= 1'b0;
			writing = 1'b0;
		end
		if (!calm_stretch() && $urandom_range(0, 99) < IDLE_PCT) begin
			pix_ch.valid <= 1'b0;
			do @(posedge clk); while (!calm_stretch() && $urandom_range(0, 99) < IDLE_PCT);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= value;
		do @(posedge clk); while (!pix_ch.ready);
		predicted = predict_gradient(value);
		expected_results.push_back(typed ? typed_want : predicted);
		pixels_sent++;
	endtask

	// result side: random stalls, periodic long hold-off, one calm stretch
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else if (cycles % HOLD_EVERY == HOLD_EVERY / 2 && !calm_stretch()) begin
				res_ch.ready <= 1'b0;
				hold_left = HOLD_CYCLES - 1;
			end else if (calm_stretch()) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// result checker: each transfer against the oldest expectation
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("t=%0t result with nothing pending: mag %0d dir %0d x %0d y %0d valid %0b",
					$time, res_ch.magnitude, res_ch.direction, res_ch.center_x,
					res_ch.center_y, res_ch.result_valid);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (want.result_valid)
					interior_seen++;
				check_field("magnitude", 12'(want.magnitude), 12'(res_ch.magnitude));
				check_field("direction", 12'(want.direction), 12'(res_ch.direction));
				check_field("center_x", 12'(want.center_x), 12'(res_ch.center_x));
				check_field("center_y", 12'(want.center_y), 12'(res_ch.center_y));
				check_field("result_valid", 12'(want.result_valid), 12'(res_ch.result_valid));
			end
		end
	end

	// stimulus
	initial begin : stimulus
		int                       random_base, frames_left, pick, new_w, new_h, new_shift;
		logic [CFG_DATA_BITS-1:0] value;
		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_IMAGE_WIDTH;
		cfg_ch.data = '0;
		reg_width = 12'd640;
		reg_height = 13'd480;
		reg_shift = '0;
		win_px = '{default: '0};
		next_col = 0;
		next_row = 0;
		level = 8'd128;
		writing = 1'b0;
		pixels_sent = 0;
		reg_writes = 0;
		settings_used = 0;
		results_checked = 0;
		interior_seen = 0;
		mismatches = 0;

		// two 3x3 frames: full-scale four-way tie, then antidiagonal under a shift of 8
		directed_rows = '{
			reg_row(CFG_IMAGE_WIDTH, 13'd3),
			reg_row(CFG_IMAGE_HEIGHT, 13'd3),
			pix_row(8'd255, BORDER_RESULT), pix_row(8'd255, BORDER_RESULT),
			pix_row(8'd255, BORDER_RESULT),
			pix_row(8'd0, BORDER_RESULT), pix_row(8'd77, BORDER_RESULT),
			pix_row(8'd255, BORDER_RESULT),
			pix_row(8'd0, BORDER_RESULT), pix_row(8'd0, BORDER_RESULT),
			pix_row(8'd0, PEAK_TIE),
			reg_row(CFG_THRESHOLD_SHIFT, 13'd8),
			pix_row(8'd0, BORDER_RESULT), pix_row(8'd0, BORDER_RESULT),
			pix_row(8'd255, BORDER_RESULT),
			pix_row(8'd0, BORDER_RESULT), pix_row(8'd0, BORDER_RESULT),
			pix_row(8'd0, BORDER_RESULT),
			pix_row(8'd0, BORDER_RESULT), pix_row(8'd0, BORDER_RESULT),
			pix_row(8'd0, ANTIDIAG_CUT)
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write) begin
				if (!writing)
					drain();
				write_reg(directed_rows[i].index, directed_rows[i].data);
			end else begin
				send_pixel(directed_rows[i].pixel, 1'b1, directed_rows[i].want);
			end
		end
		settings_used = 2;

		// widest random row; this frame writes both line stores at every column
		// that the random part can reach, so later width raises read written entries
		drain();
		write_reg(CFG_IMAGE_WIDTH, 13'(WIDE_ROW));
		write_reg(CFG_IMAGE_HEIGHT, 13'd3);
		write_reg(CFG_THRESHOLD_SHIFT, 13'd0);
		repeat (WIDE_ROW * 3)
			send_pixel(next_pixel(), 1'b0, '0);

		// saturated width, part of a first row, left for the next shrink to cut short
		drain();
		write_reg(CFG_IMAGE_WIDTH, 13'h1FFF);
		repeat (SAT_ROW_PIXELS)
			send_pixel(next_pixel(), 1'b0, '0);

		// saturated height, left mid-frame for the next shrink to cut short
		drain();
		write_reg(CFG_IMAGE_WIDTH, 13'd3);
		write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
		write_reg(CFG_THRESHOLD_SHIFT, 13'h1FFF);
		repeat (TALL_PIXELS)
			send_pixel(next_pixel(), 1'b0, '0);
		settings_used += 3;

		// random settings, whole frames mostly, partial frames otherwise
		random_base = pixels_sent;
		while (pixels_sent - random_base < RANDOM_ITEMS) begin
			drain();
			pick = $urandom_range(0, 99);
			new_w = (pick < 10) ? $urandom_range(0, 2) :
				(pick < 80) ? $urandom_range(3, 10) : $urandom_range(11, WIDE_ROW);
			pick = $urandom_range(0, 99);
			new_h = (pick < 10) ? $urandom_range(0, 2) : $urandom_range(3, 8);
			pick = $urandom_range(0, 99);
			new_shift = (pick < 60) ? $urandom_range(0, 3) :
				(pick < 85) ? $urandom_range(4, 8) : $urandom_range(9, 15);
			// the first setting must replace the tall frame
			if (settings_used == 5 || $urandom_range(0, 99) < 80) begin
				value = {1'($urandom_range(0, 1)), 12'(new_w)};
				write_reg(CFG_IMAGE_WIDTH, value);
			end
			if (settings_used == 5 || $urandom_range(0, 99) < 80)
				write_reg(CFG_IMAGE_HEIGHT, 13'(new_h));
			if (settings_used == 5 || $urandom_range(0, 99) < 80) begin
				value = {9'($urandom_range(0, 511)), 4'(new_shift)};
				write_reg(CFG_THRESHOLD_SHIFT, value);
			end
			if ($urandom_range(0, 99) < 8)
				write_reg(CFG_SPARE_INDEX, 13'($urandom_range(0, 8191)));
			settings_used++;
			if ($urandom_range(0, 99) < 75) begin
				frames_left = $urandom_range(1, 2);
				while (frames_left > 0) begin
					send_pixel(next_pixel(), 1'b0, '0);
					if (next_col == 0 && next_row == 0)
						frames_left--;
				end
			end else begin
				repeat ($urandom_range(1, 30))
					send_pixel(next_pixel(), 1'b0, '0);
			end
		end

		drain();
		repeat (6) @(posedge clk);
		$display("covered %0d pixels under %0d settings with %0d register writes",
			pixels_sent, settings_used, reg_writes);
		$display("checked %0d results, %0d interior, %0d mismatches",
			results_checked, interior_seen, mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASS directional_gradient_3x3");
		end else begin
			$display("FAIL directional_gradient_3x3");
		end
		$finish;
	end

endmodule
